>>> design/text_console_writer_core_macros.svh
// Assertion macros shared by the console checker.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

	// Field widths
	localparam int ACT_W      = 2;
	localparam int CODE_W     = 8;
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;
	localparam int COLOR_W    = 4;
	localparam int CELL_W     = 16;
	localparam int POS_W      = 11;
	// Linear position width, enough for the largest legal screen
	localparam int LIN_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// Default geometry
	localparam int DEF_SCREEN_COLUMNS = 80;
	localparam int DEF_SCREEN_ROWS    = 25;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SET   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

	// Character codes and colors
	localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [CODE_W-1:0]  SPACE_CODE   = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_FG     = 4'hF;
	localparam logic [COLOR_W-1:0] RESET_BG     = 4'h0;
	localparam logic [CELL_W-1:0]  RESET_BLANK  = {RESET_BG, RESET_FG, SPACE_CODE};

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [CODE_W-1:0] char_code;
		logic [ROW_W-1:0]  target_row;
		logic [COL_W-1:0]  target_col;
	} tcw_in_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_data;
	} tcw_out_t;

	// Cursor update request from the sequencer
	typedef struct packed {
		logic             home;
		logic             set;
		logic             newline;
		logic             advance;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} tcw_cur_cmd_t;

	// Cursor status back to the sequencer
	typedef struct packed {
		logic [LIN_W-1:0] pos;
		logic             scroll;
	} tcw_cur_stat_t;

endpackage

>>> design/text_console_writer_core.sv
// Put/newline/set/read: an accepted item goes to ST_RESP, which registers its result and strobe;
// no new item is taken until the block is back in idle. Clear: one fill write per cycle through
// the RAM port over every cell. Scroll (put or newline past the last row): one copy per cycle
// over the single read and write port, then a blank fill of the last row.
// After reset busy stays high while the screen is blanked; results are strobed for one cycle
// and cannot be stalled.
module text_console_writer_core #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  tcw_pkg::tcw_in_t                 cmd,
	input  logic                             cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             done,
	output tcw_pkg::tcw_out_t                result
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS - 1);
	localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);

	// Sequencer states
	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_RESP   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic [CELL_W-1:0]  fill_cell_q;
	logic               rd_hit_q;
	logic               done_q;
	tcw_out_t           result_q;
	logic               wr_valid_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;

	logic               accept;
	logic               in_range;
	logic               is_put;
	logic               is_nl;
	logic [LIN_W-1:0]   target_lin;
	tcw_cur_cmd_t       cur_cmd;
	tcw_cur_stat_t      cur_stat;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [CELL_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [CELL_W-1:0]  ram_rdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Input decode
	assign in_range   = (cmd.target_row < ROW_W'(SCREEN_ROWS)) &&
	                    (cmd.target_col < COL_W'(SCREEN_COLUMNS));
	assign is_put     = accept && (cmd.action == ACT_PUT);
	assign is_nl      = (cmd.char_code == NEWLINE_CODE);
	assign target_lin = LIN_W'(cmd.target_row) * LIN_W'(SCREEN_COLUMNS) +
	                    LIN_W'(cmd.target_col);

	assign cur_cmd.home    = accept && (cmd.action == ACT_CLEAR);
	assign cur_cmd.set     = accept && (cmd.action == ACT_SET) && in_range;
	assign cur_cmd.newline = is_put && is_nl;
	assign cur_cmd.advance = is_put && !is_nl;
	assign cur_cmd.row     = cmd.target_row;
	assign cur_cmd.col     = cmd.target_col;

	tcw_cursor #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cur_cmd),
		.stat  (cur_stat)
	);

	// Screen store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = fill_cell_q;
		ram_raddr = cnt_q + COLS_A;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = RESET_BLANK;
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_SCROLL, ST_DRAIN: begin
				ram_we    = wr_valid_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			ST_IDLE: begin
				ram_we    = cur_cmd.advance;
				ram_waddr = cur_stat.pos[ADDR_W-1:0];
				ram_wdata = {bg_q, fg_q, cmd.char_code};
				ram_raddr = target_lin[ADDR_W-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Color registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= RESET_FG;
			bg_q <= RESET_BG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FG: fg_q <= cfg_data;
				CFG_BG: bg_q <= cfg_data;
			endcase
		end
	end

	// Copy pipeline: read ahead one row, write back in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= (state_q == ST_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cnt_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			cnt_q    <= '0;
			rd_hit_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_hit_q <= (cmd.action == ACT_READ) && in_range;
						if (cmd.action == ACT_CLEAR) begin
							cnt_q   <= '0;
							state_q <= ST_FILL;
						end else if (cur_stat.scroll) begin
							cnt_q   <= '0;
							state_q <= ST_SCROLL;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SCROLL: begin
					// cnt_q lands on the first cell of the last row
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == COPY_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Fill value and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fill_cell_q <= {bg_q, fg_q, SPACE_CODE};
		end
		if (state_q == ST_RESP) begin
			result_q.cursor_position <= cur_stat.pos[POS_W-1:0];
			result_q.cell_data       <= rd_hit_q ? ram_rdata : '0;
		end
	end

endmodule

>>> design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/tcw_cursor.sv
// Cursor row/column registers, advance/wrap logic and linear position.
module tcw_cursor #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcw_pkg::tcw_cur_cmd_t cmd,
	output tcw_pkg::tcw_cur_stat_t stat
);
	import tcw_pkg::*;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             at_eol;
	logic             at_bottom;
	logic             line_break;

	assign at_eol     = (col_q == LAST_COL);
	assign at_bottom  = (row_q == LAST_ROW);
	assign line_break = cmd.newline || (cmd.advance && at_eol);

	// Status: linear position and whether this request runs off the bottom
	assign stat.pos    = LIN_W'(row_q) * LIN_W'(SCREEN_COLUMNS) + LIN_W'(col_q);
	assign stat.scroll = line_break && at_bottom;

	// Cursor update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else begin
			priority if (cmd.home) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.set) begin
				row_q <= cmd.row;
				col_q <= cmd.col;
			end else if (line_break) begin
				col_q <= '0;
				if (!at_bottom) begin
					row_q <= row_q + 1'b1;
				end
			end else if (cmd.advance) begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

>>> design/tcw_checker.sv
// Port-level checker for the text console writer, with its bind.
`include "text_console_writer_core_macros.svh"

module tcw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input tcw_pkg::tcw_out_t result
);

	// An accepted transfer keeps the block busy in the next cycle
	`TCW_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept without busy")

	// A result only follows a busy cycle
	`TCW_ASSERT_NOW(a_done_after_busy, clk, arst_n, done, $past(busy), "result without work")

	// Results are single-cycle strobes
	`TCW_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held")

	// The block is idle while a result is shown
	`TCW_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy && !$isunknown(result),
		"result while busy")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
